/* rtl/lpht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, slot state codes and result fields.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int MaxSlotsDefault = 128;
    localparam int KeyBytesDefault = 8;
    localparam int SizeW           = 8;
    localparam logic [SizeW-1:0] SizeReset = 8'd100;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [1:0] RS_DONE     = 2'd0;
    localparam logic [1:0] RS_NOTFOUND = 2'd1;
    localparam logic [1:0] RS_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic        replaced;
        logic [31:0] value_out;
        logic [7:0]  element_count;
    } t_result;

endpackage

/* rtl/linear_probe_hash_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table top level
// Open-addressing table with linear probing, tombstones and a stream port.
// ----------------------------------------------------------------------------
// After acceptance the key is hashed byte by byte, then the probe starts; each
// probed slot takes one memory read and one evaluate step, and a finishing step
// hands the result on; a put refused as full skips the probe and goes to finish.
// One transaction at a time; the next is accepted at the earliest in the cycle
// after the result has been taken.
// Reset is synchronous, active low; after reset a clearing pass marks every slot
// empty while no transaction is accepted.
module linear_probe_hash_table_top #(
    parameter int MAX_SLOTS = lpht_pkg::MaxSlotsDefault,
    parameter int KEY_BYTES = lpht_pkg::KeyBytesDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata fields from bit 0: op[1:0], key[65:2], value[97:66], zero fill.
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata fields from bit 0: status[1:0], replaced[2], value_out[34:3],
    // element_count[42:35], zero fill.
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata
);
    import lpht_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_HASH = 2'd1;
    localparam logic [1:0] T_PROBE = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       r_op;
    logic [63:0]      r_key_raw;
    logic [31:0]      r_value;
    logic [SizeW-1:0] r_size;
    logic             r_ovalid;
    t_result          r_out;

    logic             w_accept;
    logic             w_hdone;
    logic [63:0]      w_ckey;
    logic [SizeW-1:0] w_home;
    logic [SizeW-1:0] w_hsize;
    logic             w_pready;
    logic             w_pdone;
    t_result          w_res;

    // The configured size is clamped here so the hash sees a legal modulus; the probe clamps its own copy.
    always_comb begin
        w_hsize = (r_size < 8'd2) ? 8'd2 :
                  (r_size > SizeW'((MAX_SLOTS < 128) ? MAX_SLOTS : 128)) ?
                  SizeW'((MAX_SLOTS < 128) ? MAX_SLOTS : 128) : r_size;
    end

    // A new transaction is taken only when idle, the result slot is empty and
    // the probe engine has finished its clearing pass.
    assign s_axis_tready = (r_state == T_IDLE) && !r_ovalid && w_pready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // The hash works from the registered key, so the sender may move on to
    // its next transaction as soon as this one is accepted.
    lpht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (r_key_raw),
        .i_size  (w_hsize),
        .o_done  (w_hdone),
        .o_key   (w_ckey),
        .o_home  (w_home)
    );

    lpht_probe #(.MAX_SLOTS(MAX_SLOTS)) u_probe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hdone),
        .i_op     (r_op),
        .i_key    (w_ckey),
        .i_value  (r_value),
        .i_home   (w_home),
        .i_size   (r_size),
        .o_ready  (w_pready),
        .o_done   (w_pdone),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_ovalid <= 1'b0;
            r_size   <= SizeReset;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_op      <= s_axis_tdata[1:0];
                        r_key_raw <= s_axis_tdata[65:2];
                        r_value   <= s_axis_tdata[97:66];
                        r_state   <= T_HASH;
                    end
                end
                T_HASH: begin
                    if (w_hdone) begin
                        r_state <= T_PROBE;
                    end
                end
                T_PROBE: begin
                    if (w_pdone) begin
                        r_out    <= w_res;
                        r_ovalid <= 1'b1;
                        r_state  <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_out.element_count, r_out.value_out,
                            r_out.replaced, r_out.status};

    // No new transaction may start while a result still waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready)
        else $error("accept while result pending");

    // The probe only finishes while the top level waits for it.
    a_done_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pdone |-> r_state == T_PROBE)
        else $error("probe done outside probe phase");

    // The raw key is held stable while it is hashed.
    a_key_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_HASH && $past(r_state) == T_HASH) |-> $stable(r_key_raw))
        else $error("key changed during hashing");

    // A full answer never reports a replace.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pdone && w_res.status == RS_FULL && !$past(!i_rst_n)) |-> !w_res.replaced)
        else $error("full result marked replaced");

endmodule

/* rtl/lpht_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table home slot unit
// Cuts the key at its first zero byte and folds one byte per cycle
// into the home slot, reducing modulo the table size.
// ----------------------------------------------------------------------------
module lpht_hash #(
    parameter int KEY_BYTES = lpht_pkg::KeyBytesDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [63:0]             i_key,
    input  logic [lpht_pkg::SizeW-1:0] i_size,
    output logic                    o_done,
    output logic [63:0]             o_key,
    output logic [lpht_pkg::SizeW-1:0] o_home
);
    import lpht_pkg::*;

    localparam int CntW = $clog2(KEY_BYTES + 1);

    logic [63:0]      r_key;
    logic [SizeW-1:0] r_h;
    logic [CntW-1:0]  r_idx;
    logic             r_busy;
    logic             r_done;
    logic             r_stop;

    logic [7:0]  w_byte;
    logic [15:0] w_acc;
    logic [15:0] w_rem;
    logic [15:0] w_sz;
    logic        w_last;

    always_comb begin
        w_byte = i_key[8*r_idx[$clog2(KEY_BYTES)-1+((KEY_BYTES==1)?1:0):0] +: 8];
        w_sz   = {8'd0, i_size};
        w_acc  = {r_h, w_byte};
        // Reduce a 16-bit value below 256*size by restoring subtraction of
        // size*2^k for k from 7 down to 0.
        w_rem  = w_acc;
        for (int k = 7; k >= 0; k--) begin
            if (w_rem >= (w_sz << k)) begin
                w_rem = w_rem - (w_sz << k);
            end
        end
        w_last = (r_idx == CntW'(KEY_BYTES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_h    <= '0;
                r_key  <= '0;
                r_stop <= 1'b0;
            end else if (r_busy) begin
                if (!r_stop && w_byte != 8'd0) begin
                    r_h <= w_rem[SizeW-1:0];
                    r_key[8*r_idx +: 8] <= w_byte;
                end else begin
                    r_stop <= 1'b1;
                end
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_key  = r_key;
    assign o_home = r_h;

endmodule

/* rtl/lpht_probe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table probe engine
// Walks the slot memories from the home slot, evaluating each read slot before
// the next read, and performs put, get and remove with at most a single write back.
// ----------------------------------------------------------------------------
module lpht_probe #(
    parameter int MAX_SLOTS = lpht_pkg::MaxSlotsDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [1:0]                 i_op,
    input  logic [63:0]                i_key,
    input  logic [31:0]                i_value,
    input  logic [lpht_pkg::SizeW-1:0] i_home,
    input  logic [lpht_pkg::SizeW-1:0] i_size,
    output logic                       o_ready,
    output logic                       o_done,
    output lpht_pkg::t_result          o_result
);
    import lpht_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int SlotCap = (MAX_SLOTS < 128) ? MAX_SLOTS : 128;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [63:0] r_mkey [MAX_SLOTS];
    logic [31:0] r_mval [MAX_SLOTS];
    logic [1:0]  r_mst  [MAX_SLOTS];

    logic [63:0] r_rkey;
    logic [31:0] r_rval;
    logic [1:0]  r_rst;

    logic [2:0]       r_state;
    logic [AW-1:0]    r_clr;
    logic [SizeW-1:0] r_idx;
    logic [SizeW:0]   r_n;
    logic             r_tvalid;
    logic [SizeW-1:0] r_tomb;
    logic [SizeW-1:0] r_count;
    logic [1:0]       r_op;
    logic [SizeW-1:0] r_size;
    t_result          r_res;
    logic             r_done;

    logic             w_we_k, w_we_v, w_we_s;
    logic [AW-1:0]    w_waddr;
    logic [1:0]       w_wst;
    logic [AW-1:0]    w_raddr;
    logic [SizeW-1:0] w_next;
    logic [SizeW-1:0] w_sz;
    logic             w_full;

    always_comb begin
        w_sz   = (i_size < 8'd2) ? 8'd2 :
                 (i_size > SizeW'(SlotCap)) ? SizeW'(SlotCap) : i_size;
        w_next = (r_idx + 1'b1 == r_size) ? '0 : r_idx + 1'b1;
        w_raddr = AW'(r_idx);
        w_full = (i_op == OP_PUT) &&
                 (({r_count, 2'b00} + 10'd4) > ({2'b00, w_sz} + {1'b0, w_sz, 1'b0}));
    end

    // Slot memories: one read and one write port each.
    always_ff @(posedge i_clk) begin
        if (w_we_k) begin
            r_mkey[w_waddr] <= i_key;
        end
        if (w_we_v) begin
            r_mval[w_waddr] <= i_value;
        end
        if (w_we_s) begin
            r_mst[w_waddr] <= w_wst;
        end
        r_rkey <= r_mkey[w_raddr];
        r_rval <= r_mval[w_raddr];
        r_rst  <= r_mst[w_raddr];
    end

    always_comb begin
        w_we_k  = 1'b0;
        w_we_v  = 1'b0;
        w_we_s  = 1'b0;
        w_waddr = AW'(r_idx);
        w_wst   = ST_EMPTY;
        if (r_state == S_CLR) begin
            w_we_s  = 1'b1;
            w_waddr = r_clr;
        end else if (r_state == S_EVAL && r_op == OP_PUT) begin
            if (r_rst == ST_LIVE && r_rkey == i_key) begin
                w_we_v = 1'b1;
            end else if (r_rst == ST_EMPTY || r_n + 1'b1 == {1'b0, r_size}) begin
                if (r_tvalid || r_rst == ST_EMPTY) begin
                    w_we_k = 1'b1;
                    w_we_v = 1'b1;
                    w_we_s = 1'b1;
                    w_wst  = ST_LIVE;
                    w_waddr = r_tvalid ? AW'(r_tomb) : AW'(r_idx);
                end else if (r_rst == ST_TOMB) begin
                    w_we_k = 1'b1;
                    w_we_v = 1'b1;
                    w_we_s = 1'b1;
                    w_wst  = ST_LIVE;
                end
            end
        end else if (r_state == S_EVAL && r_op == OP_REMOVE) begin
            if (r_rst == ST_LIVE && r_rkey == i_key) begin
                w_we_s = 1'b1;
                w_wst  = ST_TOMB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    if (r_clr == AW'(MAX_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op     <= i_op;
                        r_size   <= w_sz;
                        r_idx    <= i_home;
                        r_n      <= '0;
                        r_tvalid <= 1'b0;
                        r_res    <= '{w_full ? RS_FULL : RS_NOTFOUND, 1'b0, 32'd0, r_count};
                        if (w_full) begin
                            r_state <= S_FIN;
                        end else if (i_op == OP_PUT || i_op == OP_GET || i_op == OP_REMOVE) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_rst == ST_LIVE && r_rkey == i_key) begin
                        r_res.status    <= RS_DONE;
                        r_res.value_out <= r_rval;
                        r_res.replaced  <= (r_op == OP_PUT);
                        if (r_op == OP_REMOVE) begin
                            r_count <= r_count - 1'b1;
                            r_res.element_count <= r_count - 1'b1;
                        end
                        r_state <= S_FIN;
                    end else if (r_rst == ST_EMPTY || r_n + 1'b1 == {1'b0, r_size}) begin
                        r_state <= S_FIN;
                        if (r_op == OP_PUT) begin
                            if (r_tvalid || r_rst == ST_EMPTY || r_rst == ST_TOMB) begin
                                r_res.status <= RS_DONE;
                                if (r_count != 8'hFF) begin
                                    r_count <= r_count + 1'b1;
                                    r_res.element_count <= r_count + 1'b1;
                                end
                            end else begin
                                r_res.status <= RS_FULL;
                            end
                        end
                    end else begin
                        if (r_rst == ST_TOMB && !r_tvalid) begin
                            r_tvalid <= 1'b1;
                            r_tomb   <= r_idx;
                        end
                        r_idx   <= w_next;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
